[hdl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MaxSegments = 64;
  localparam int ArenaBytes  = 1048576;
  localparam int HeaderBytes = 32;
  localparam int IdxW        = $clog2(MaxSegments);
  localparam int CntW        = $clog2(MaxSegments + 1);
  localparam int LenW        = 21;
  localparam int AddrW       = 20;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoSpace  = 2'd1;
  localparam logic [1:0] StatusBadFree  = 2'd2;

  localparam logic [LenW-1:0] ArenaBound = LenW'(ArenaBytes);
  localparam logic [LenW-1:0] HeaderLen  = LenW'(HeaderBytes);

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_EVAL,
    ST_SHIFT_UP,
    ST_SHIFT_RD,
    ST_NEXT_RD,
    ST_NEXT_EVAL,
    ST_PREV_RD,
    ST_PREV_EVAL,
    ST_SHIFT_DN,
    ST_SHIFT_DN_RD,
    ST_FREE_WR,
    ST_TRIM,
    ST_TRIM_EVAL,
    ST_DONE
  } state_t;

  // table write request
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [LenW-1:0] len;
    logic            is_free;
  } tbl_wr_t;

endpackage

[hdl/ffha_table.sv]
// ----------------------------------------------------------------------------
// ffha_table
// Segment table: length and free flag per slot, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module ffha_table
  import ffha_pkg::*;
(
  input  logic            clk,
  input  tbl_wr_t         wr,
  input  logic [IdxW-1:0] rd_addr,
  output logic [LenW-1:0] rd_len,
  output logic            rd_free
);

  logic [LenW:0] mem [MaxSegments];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.is_free, wr.len};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    {rd_free, rd_len} <= mem[rd_addr];
  end

endmodule

[hdl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with split, coalescing and break trimming over a
// segment table walked one entry at a time.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// command   in         start && !busy         action, req_size, free_addr
// result    out        done (one cycle)       status, payload_addr, break_offset
// config    in         apb write, pready=1    arena_limit at address 0
//
// An item walks the table entry by entry (n entries walked, at most 64),
// shifts entries on a split or a merge and trims trailing free segments;
// it also passes through accept, end of walk and done, and on a free through
// the neighbor checks and the table update.
// The table's one registered read port sets the pace: read, then evaluate.
// Reset is synchronous; the table needs no clearing, entries past the live
// count are never used. The receiver cannot stall: done pulses one cycle.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             start,
  output logic             busy,
  input  logic             action,
  input  logic [AddrW-1:0] req_size,
  input  logic [AddrW-1:0] free_addr,
  output logic             done,
  output logic [1:0]       status,
  output logic [AddrW-1:0] payload_addr,
  output logic [LenW-1:0]  break_offset
);

  state_t state, state_next;

  logic [LenW-1:0] arena_limit;
  logic [CntW-1:0] seg_total;
  logic [LenW-1:0] heap_break;

  // per-item working registers
  logic            op_free;
  logic [LenW:0]   need;
  logic [AddrW-1:0] addr;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] hit;
  logic [CntW-1:0] ptr;
  logic [LenW+1:0] seg_start;
  logic [LenW-1:0] hold_len;
  logic            hold_free;
  logic [LenW-1:0] cur_len;
  logic [LenW-1:0] ins_len;
  logic            prev_phase;

  tbl_wr_t         wr;
  logic [IdxW-1:0] rd_addr;
  logic [LenW-1:0] rd_len;
  logic            rd_free;

  ffha_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_len  (rd_len),
    .rd_free (rd_free)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {11'd0, arena_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_limit <= ArenaBound;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      arena_limit <= pwdata[LenW-1:0];
    end
  end

  // shared compare terms
  logic [LenW-1:0] bound;
  logic            fits;
  logic            addr_ok;
  logic [LenW+1:0] excess;
  logic [LenW+1:0] brk_need;
  logic            append_ok;
  logic [LenW-1:0] trim_break;

  assign bound     = (arena_limit > ArenaBound) ? ArenaBound : arena_limit;
  assign fits      = rd_free && ({1'b0, rd_len} >= need);
  assign addr_ok   = (seg_start + (LenW+2)'(HeaderBytes)) <= (LenW+2)'(20'hFFFFF);
  assign excess    = (LenW+2)'(rd_len) - (LenW+2)'(need);
  assign brk_need  = (LenW+2)'(heap_break) + (LenW+2)'(need);
  assign append_ok = (seg_total < CntW'(MaxSegments)) && (brk_need <= (LenW+2)'(bound))
                     && ((LenW+2)'(heap_break) + (LenW+2)'(HeaderBytes)
                         <= (LenW+2)'(20'hFFFFF));
  assign trim_break = (rd_len > heap_break) ? '0 : heap_break - rd_len;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (start) state_next = ST_SCAN;
      ST_SCAN:       state_next = (idx >= seg_total) ? ST_DONE : ST_SCAN_EVAL;
      ST_SCAN_EVAL: begin
        state_next = ST_SCAN;
        if (!op_free && fits && addr_ok) begin
          state_next = ((excess > (LenW+2)'(HeaderBytes)) &&
                        (seg_total < CntW'(MaxSegments))) ? ST_SHIFT_UP : ST_DONE;
        end else if (op_free && (seg_start + (LenW+2)'(HeaderBytes)
                                 == (LenW+2)'(addr))) begin
          state_next = rd_free ? ST_DONE : ST_NEXT_RD;
        end
      end
      ST_SHIFT_UP:   state_next = (ptr > hit + 1'b1) ? ST_SHIFT_RD : ST_DONE;
      ST_SHIFT_RD:   state_next = ST_SHIFT_UP;
      ST_NEXT_RD:    state_next = ST_NEXT_EVAL;
      ST_NEXT_EVAL:  state_next = (hit + 1'b1 < seg_total && rd_free) ? ST_SHIFT_DN
                                                                      : ST_PREV_RD;
      ST_PREV_RD:    state_next = (hit == '0) ? ST_FREE_WR : ST_PREV_EVAL;
      ST_PREV_EVAL:  state_next = rd_free ? ST_SHIFT_DN : ST_FREE_WR;
      ST_SHIFT_DN: begin
        if (ptr + 1'b1 < seg_total) begin
          state_next = ST_SHIFT_DN_RD;
        end else begin
          state_next = prev_phase ? ST_FREE_WR : ST_PREV_RD;
        end
      end
      ST_SHIFT_DN_RD: state_next = ST_SHIFT_DN;
      ST_FREE_WR:    state_next = ST_TRIM;
      ST_TRIM:       state_next = (seg_total == '0) ? ST_DONE : ST_TRIM_EVAL;
      ST_TRIM_EVAL:  state_next = rd_free ? ST_TRIM : ST_DONE;
      ST_DONE:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // table address and write
  always_comb begin
    rd_addr = idx[IdxW-1:0];
    wr      = '0;
    unique case (state)
      ST_SHIFT_UP:    rd_addr = IdxW'(ptr - 1'b1);
      ST_NEXT_RD:     rd_addr = IdxW'(hit + 1'b1);
      ST_PREV_RD:     rd_addr = IdxW'(hit - 1'b1);
      ST_SHIFT_DN:    rd_addr = IdxW'(ptr + 1'b1);
      ST_TRIM:        rd_addr = IdxW'(seg_total - 1'b1);
      default:        rd_addr = idx[IdxW-1:0];
    endcase
    unique case (state)
      ST_SHIFT_UP: begin
        // place the split remainder after the granted segment
        if (!(ptr > hit + 1'b1)) begin
          wr = '{en: 1'b1, addr: IdxW'(ptr), len: ins_len, is_free: 1'b1};
        end
      end
      ST_SHIFT_RD: begin
        wr = '{en: 1'b1, addr: IdxW'(ptr), len: rd_len, is_free: rd_free};
      end
      ST_SHIFT_DN_RD: begin
        wr = '{en: 1'b1, addr: IdxW'(ptr), len: rd_len, is_free: rd_free};
      end
      ST_FREE_WR: begin
        wr = '{en: 1'b1, addr: IdxW'(hit), len: cur_len, is_free: hold_free};
      end
      ST_DONE: begin
        wr = '{en: (hit != '1) && !op_free,
               addr: IdxW'(hit), len: cur_len, is_free: 1'b0};
      end
      default: wr = '0;
    endcase
  end

  // datapath and sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seg_total  <= '0;
      heap_break <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ST_IDLE: if (start) begin
          op_free   <= action;
          need      <= (LenW+1)'(req_size) + (LenW+1)'(HeaderBytes);
          addr      <= free_addr;
          idx       <= (action && free_addr == '0) ? seg_total : '0;
          seg_start <= '0;
          hit       <= '1;
          ins_len   <= '0;
          hold_free <= 1'b0;
          prev_phase <= 1'b0;
          status    <= StatusOk;
          payload_addr <= '0;
        end
        ST_SCAN: begin
          if (idx >= seg_total) begin
            // walk finished without a match
            if (!op_free) begin
              if (append_ok) begin
                payload_addr <= AddrW'(heap_break + HeaderLen);
                heap_break   <= brk_need[LenW-1:0];
                hit          <= seg_total;
                cur_len      <= need[LenW-1:0];
                seg_total    <= seg_total + 1'b1;
              end else begin
                status <= StatusNoSpace;
              end
            end else if (addr != '0) begin
              status <= StatusBadFree;
            end
          end
        end
        ST_SCAN_EVAL: begin
          idx       <= idx + 1'b1;
          seg_start <= seg_start + (LenW+2)'(rd_len);
          if (!op_free && fits && addr_ok) begin
            hit          <= idx;
            ptr          <= seg_total;
            payload_addr <= AddrW'(seg_start + (LenW+2)'(HeaderBytes));
            cur_len      <= rd_len;
            if ((excess > (LenW+2)'(HeaderBytes)) && (seg_total < CntW'(MaxSegments))) begin
              cur_len   <= need[LenW-1:0];
              ins_len   <= excess[LenW-1:0];
              seg_total <= seg_total + 1'b1;
            end
          end else if (op_free && (seg_start + (LenW+2)'(HeaderBytes)
                                   == (LenW+2)'(addr))) begin
            if (rd_free) begin
              status <= StatusBadFree;
              hit    <= '1;
            end else begin
              hit       <= idx;
              cur_len   <= rd_len;
              hold_free <= 1'b1;
            end
          end
        end
        ST_SHIFT_RD: ptr <= ptr - 1'b1;
        ST_NEXT_EVAL: begin
          if (hit + 1'b1 < seg_total && rd_free) begin
            cur_len <= cur_len + rd_len;
            ptr     <= hit + 1'b1;
          end
        end
        ST_PREV_RD: prev_phase <= 1'b1;
        ST_PREV_EVAL: begin
          if (rd_free) begin
            cur_len <= rd_len + cur_len;
            ptr     <= hit;
            hit     <= hit - 1'b1;
          end
        end
        ST_SHIFT_DN: begin
          if (!(ptr + 1'b1 < seg_total)) begin
            seg_total <= seg_total - 1'b1;
          end
        end
        ST_SHIFT_DN_RD: ptr <= ptr + 1'b1;
        ST_TRIM_EVAL: begin
          if (rd_free) begin
            heap_break <= trim_break;
            seg_total  <= seg_total - 1'b1;
          end
        end
        ST_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy         = (state != ST_IDLE);
  assign break_offset = heap_break;

endmodule

[sim/tb_first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator. A queue-fed driver
// issues allocate and free commands in batches, a segment-table model in the
// bench predicts each result, and a monitor checks every done pulse in order.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  typedef struct {
    logic             act;
    logic [AddrW-1:0] size;
    logic [AddrW-1:0] ptr;
    int               gap;
  } heap_cmd_t;

  typedef struct {
    logic [1:0]       st;
    logic [AddrW-1:0] grant;
    logic [LenW-1:0]  brk;
  } heap_resp_t;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;
  localparam int   WatchdogCycles = 20000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             start = 1'b0;
  logic             busy;
  logic             action = 1'b0;
  logic [AddrW-1:0] req_size = '0;
  logic [AddrW-1:0] free_addr = '0;
  logic             done;
  logic [1:0]       status;
  logic [AddrW-1:0] payload_addr;
  logic [LenW-1:0]  break_offset;

  heap_cmd_t        cmd_q[$];
  heap_resp_t       resp_q[$];
  logic [AddrW-1:0] live_ptrs[$];
  int               errors = 0;
  int               wait_cnt = 0;
  int               idle_cycles = 0;

  // heap model state
  logic [LenW-1:0]  seg_len[MaxSegments];
  bit               seg_free[MaxSegments];
  int               seg_cnt = 0;
  logic [LenW-1:0]  heap_brk = '0;
  logic [LenW-1:0]  limit_reg = ArenaBound;

  first_fit_heap_allocator dut (.*);

  always #10 clk = ~clk;

  // drop a pointer from the list of granted payloads
  function automatic void forget_ptr(logic [AddrW-1:0] p);
    foreach (live_ptrs[k]) if (live_ptrs[k] == p) begin
      live_ptrs.delete(k);
      return;
    end
  endfunction

  // first-fit allocate with split, append at the break
  function automatic heap_resp_t heap_alloc(logic [AddrW-1:0] size);
    heap_resp_t r;
    longint need, base, bound, excess;
    need = HeaderBytes + size;
    base = 0;
    bound = (limit_reg > ArenaBound) ? ArenaBound : limit_reg;
    r.st = StatusNoSpace;
    r.grant = '0;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_free[i] && seg_len[i] >= need && base + HeaderBytes <= 20'hFFFFF) begin
        excess = seg_len[i] - need;
        seg_free[i] = 1'b0;
        if (excess > HeaderBytes && seg_cnt < MaxSegments) begin
          seg_len[i] = LenW'(need);
          for (int k = seg_cnt; k > i + 1; k--) begin
            seg_len[k] = seg_len[k-1];
            seg_free[k] = seg_free[k-1];
          end
          seg_len[i+1] = LenW'(excess);
          seg_free[i+1] = 1'b1;
          seg_cnt++;
        end
        r.st = StatusOk;
        r.grant = AddrW'(base + HeaderBytes);
        live_ptrs.push_back(r.grant);
        return r;
      end
      base += seg_len[i];
    end
    if (seg_cnt < MaxSegments && heap_brk + need <= bound &&
        heap_brk + HeaderBytes <= 20'hFFFFF) begin
      seg_len[seg_cnt] = LenW'(need);
      seg_free[seg_cnt] = 1'b0;
      seg_cnt++;
      r.st = StatusOk;
      r.grant = AddrW'(heap_brk + HeaderBytes);
      heap_brk = LenW'(heap_brk + need);
      live_ptrs.push_back(r.grant);
    end
    return r;
  endfunction

  // release with neighbour merging and break trimming
  function automatic heap_resp_t heap_free(logic [AddrW-1:0] ptr);
    heap_resp_t r;
    longint base;
    int idx;
    r.grant = '0;
    r.st = StatusOk;
    if (ptr == 0) return r;
    base = 0;
    idx = -1;
    for (int i = 0; i < seg_cnt; i++) begin
      if (base + HeaderBytes == ptr) begin
        if (!seg_free[i]) idx = i;
        break;
      end
      base += seg_len[i];
    end
    if (idx < 0) begin
      r.st = StatusBadFree;
      return r;
    end
    forget_ptr(ptr);
    seg_free[idx] = 1'b1;
    if (idx + 1 < seg_cnt && seg_free[idx+1]) begin
      seg_len[idx] = seg_len[idx] + seg_len[idx+1];
      for (int k = idx + 1; k + 1 < seg_cnt; k++) begin
        seg_len[k] = seg_len[k+1];
        seg_free[k] = seg_free[k+1];
      end
      seg_cnt--;
    end
    if (idx > 0 && seg_free[idx-1]) begin
      seg_len[idx-1] = seg_len[idx-1] + seg_len[idx];
      for (int k = idx; k + 1 < seg_cnt; k++) begin
        seg_len[k] = seg_len[k+1];
        seg_free[k] = seg_free[k+1];
      end
      seg_cnt--;
    end
    while (seg_cnt > 0 && seg_free[seg_cnt-1]) begin
      heap_brk = (seg_len[seg_cnt-1] > heap_brk) ? '0 : heap_brk - seg_len[seg_cnt-1];
      seg_cnt--;
    end
    return r;
  endfunction

  // command driver: predict on acceptance, launch the next command after its gap
  always @(posedge clk) begin
    heap_resp_t r;
    heap_cmd_t c;
    if (rst) begin
      start <= 1'b0;
      wait_cnt <= 0;
    end else begin
      if (start && !busy) begin
        r = (action == ActAlloc) ? heap_alloc(req_size) : heap_free(free_addr);
        r.brk = heap_brk;
        resp_q.push_back(r);
      end
      if (!start || !busy) begin
        if (cmd_q.size() > 0 && wait_cnt >= cmd_q[0].gap) begin
          c = cmd_q.pop_front();
          action <= c.act;
          req_size <= c.size;
          free_addr <= c.ptr;
          start <= 1'b1;
          wait_cnt <= 0;
        end else begin
          start <= 1'b0;
          if (cmd_q.size() > 0) wait_cnt <= wait_cnt + 1;
        end
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    heap_resp_t e;
    if (!rst) begin
      if (done) begin
        if (resp_q.size() == 0) begin
          $display("%0t: result with no transaction pending: status %0d addr %0d brk %0d",
                   $time, status, payload_addr, break_offset);
          errors++;
        end else begin
          e = resp_q.pop_front();
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (payload_addr !== e.grant) begin
            $display("%0t: payload_addr expected %0d actual %0d", $time, e.grant,
                     payload_addr);
            errors++;
          end
          if (break_offset !== e.brk) begin
            $display("%0t: break_offset expected %0d actual %0d", $time, e.brk,
                     break_offset);
            errors++;
          end
        end
      end
      if (done || (start && !busy) || (psel && penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogCycles) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // random gap for one command, zero for a whole batch when burst is set
  function automatic int pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [AddrW-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return AddrW'($urandom_range(0, 255));
    if (sel < 90) return AddrW'($urandom_range(0, 8191));
    if (sel < 97) return AddrW'($urandom_range(0, 200000));
    return AddrW'($urandom);
  endfunction

  task automatic push_cmd(logic act, logic [AddrW-1:0] size, logic [AddrW-1:0] ptr,
                          bit burst);
    heap_cmd_t c;
    c.act = act;
    c.size = size;
    c.ptr = ptr;
    c.gap = pick_gap(burst);
    cmd_q.push_back(c);
  endtask

  // hold until every command went out and every result came back
  task automatic drain();
    @(negedge clk);
    while (cmd_q.size() > 0 || start || resp_q.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb register write, only called while the block is idle
  task automatic set_limit(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= value;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    limit_reg = value[LenW-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic free_everything();
    logic [AddrW-1:0] snap[$];
    snap = live_ptrs;
    foreach (snap[k]) push_cmd(ActFree, pick_size(), snap[k], 1'b0);
    drain();
  endtask

  // stimulus
  initial begin
    logic [AddrW-1:0] p;
    int sel;
    bit burst;
    logic [31:0] limits[5];
    limits = '{32'd1048576, 32'hFFE00BB8, 32'd0, 32'h001FFFFF, 32'd20000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: null free, bad free, oversize, split, merge, double free, trim
    push_cmd(ActFree, '0, '0, 1'b0);
    push_cmd(ActFree, '0, 20'd5, 1'b0);
    push_cmd(ActAlloc, 20'hFFFFF, '0, 1'b0);
    push_cmd(ActAlloc, '0, '0, 1'b0);
    push_cmd(ActAlloc, 20'd100, '0, 1'b0);
    push_cmd(ActAlloc, 20'd100, '0, 1'b0);
    push_cmd(ActAlloc, 20'd100, '0, 1'b0);
    push_cmd(ActFree, '0, 20'd64, 1'b0);
    push_cmd(ActFree, '0, 20'd196, 1'b0);
    push_cmd(ActFree, '0, 20'd196, 1'b0);
    push_cmd(ActAlloc, 20'd10, '0, 1'b0);
    push_cmd(ActFree, '0, 20'd328, 1'b0);
    push_cmd(ActFree, '0, 20'hFFFFF, 1'b1);
    drain();
    free_everything();

    // payload offset near the top of the 20-bit range
    push_cmd(ActAlloc, 20'd1048510, '0, 1'b1);
    push_cmd(ActAlloc, '0, '0, 1'b1);
    push_cmd(ActAlloc, '0, '0, 1'b1);
    drain();
    free_everything();

    // fill the table, then reuse a hole while no slot is free
    for (int k = 0; k < MaxSegments + 1; k++) push_cmd(ActAlloc, 20'd100, '0, 1'b1);
    drain();
    push_cmd(ActFree, '0, live_ptrs[5], 1'b0);
    push_cmd(ActAlloc, '0, '0, 1'b0);
    drain();
    free_everything();

    // limit below the current break
    push_cmd(ActAlloc, 20'd4000, '0, 1'b0);
    drain();
    set_limit(32'hFFE00BB8);
    push_cmd(ActFree, '0, live_ptrs[0], 1'b0);
    push_cmd(ActAlloc, 20'd100, '0, 1'b0);
    push_cmd(ActAlloc, 20'd5000, '0, 1'b0);
    drain();
    free_everything();

    // random batches
    for (int b = 0; b < 120; b++) begin
      if (b % 24 == 0) set_limit(limits[(b / 24) % 5]);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 10; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55 || live_ptrs.size() == 0) begin
          push_cmd(ActAlloc, pick_size(), AddrW'($urandom), burst);
        end else if (sel < 93) begin
          p = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
          push_cmd(ActFree, AddrW'($urandom), p, burst);
        end else if (sel < 96) begin
          push_cmd(ActFree, AddrW'($urandom), '0, burst);
        end else begin
          push_cmd(ActFree, AddrW'($urandom), AddrW'($urandom), burst);
        end
      end
      drain();
      if (b % 25 == 24) free_everything();
    end
    set_limit(32'd1048576);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ffha_pkg.sv
hdl/ffha_table.sv
hdl/first_fit_heap_allocator.sv
sim/tb_first_fit_heap_allocator.sv
